>>> design/pps_pkg.sv
// pps_pkg: shared sizes and the task table entry layout for the priority scheduler
// no dependencies
`default_nettype none

package pps_pkg;

	// table size and derived index widths
	localparam int MAX_TASKS = 16;
	localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	// time fields
	localparam int          TIME_W   = 16;
	localparam logic [15:0] TIME_MAX = 16'hFFFF;

	// item opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// one table entry, kept in the task memory
	typedef struct packed {
		logic [7:0]        pid;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [7:0]        prio;
		logic [TIME_W-1:0] left;
		logic              started;
		logic [TIME_W-1:0] resp;
	} task_entry_t;

	localparam int ENTRY_W = $bits(task_entry_t);

endpackage

`default_nettype wire

>>> design/pps_ram.sv
// pps_ram: generic single write, single read port ram with registered read data
// no dependencies
`default_nettype none

module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/preemptive_priority_scheduler_top.sv
// preemptive_priority_scheduler_top: task table, ready scan and one-unit dispatch
// depends on pps_pkg and pps_ram
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   request | req_valid | req_stall | opcode pid_in arrival_in burst_in priority_in
//   result  | rsp_valid | rsp_stall | load_error idle slot pid_out ... idle_total
//
// a load writes its entry in its final step; a tick scans the loaded entries, reading one
// table entry per cycle through the memory read port (an empty table skips the scan).
// reset clears counters and control only; the table memory is not cleared.
// a result waits in the output register while the next item is accepted and worked;
// that item holds in its final step until the output register is free.
`default_nettype none

module preemptive_priority_scheduler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        opcode,
	input  wire logic [7:0]  pid_in,
	input  wire logic [15:0] arrival_in,
	input  wire logic [15:0] burst_in,
	input  wire logic [7:0]  priority_in,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             load_error,
	output logic             idle,
	output logic [3:0]       slot,
	output logic [7:0]       pid_out,
	output logic             new_slice,
	output logic             finished,
	output logic [15:0]      finish_time,
	output logic [15:0]      turnaround,
	output logic [15:0]      waiting,
	output logic [15:0]      response,
	output logic             all_done,
	output logic [15:0]      idle_total
);

	import pps_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOAD   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q;

	// counters and scheduler status
	logic [CNT_W-1:0]  loaded_q;
	logic [CNT_W-1:0]  completed_q;
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] idle_cnt_q;
	logic              prev_valid_q;
	logic [SLOT_W-1:0] prev_slot_q;

	// captured load fields
	logic [7:0]        pid_q;
	logic [TIME_W-1:0] arrival_q;
	logic [TIME_W-1:0] burst_q;
	logic [7:0]        prio_q;

	// scan state
	logic [CNT_W-1:0]  scan_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_slot_s1;
	logic              found_q;
	logic [SLOT_W-1:0] best_slot_q;
	task_entry_t       best_q;

	// memory ports
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	task_entry_t       ram_wdata;
	logic              ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	task_entry_t       rd_ent;

	logic out_free;
	logic rsp_set;
	logic req_xfer;
	logic issue;
	logic load_ok;
	logic cand_ready;
	logic cand_better;

	// commit datapath
	logic [TIME_W-1:0] time_inc;
	logic [TIME_W-1:0] idle_inc;
	logic [TIME_W-1:0] left_dec;
	logic [TIME_W-1:0] resp_val;
	logic [TIME_W-1:0] tat;
	logic [TIME_W-1:0] wt;
	logic              done_now;
	logic [CNT_W-1:0]  loaded_nxt;
	logic [CNT_W-1:0]  completed_nxt;
	logic [SLOT_W+3:0] slot_ext;
	task_entry_t       upd_ent;
	task_entry_t       new_ent;

	pps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_TASKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_q[SLOT_W-1:0]),
		.rdata(ram_rdata)
	);

	// handshake
	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign out_free  = !rsp_valid || !rsp_stall;
	assign rsp_set   = ((state_q == ST_LOAD) || (state_q == ST_COMMIT)) && out_free;

	// scan read issue and candidate compare
	assign issue  = (state_q == ST_SCAN) && (scan_q < loaded_q);
	assign ram_re = issue;
	assign rd_ent = task_entry_t'(ram_rdata);

	assign cand_ready  = (rd_ent.arrival <= time_q) && (rd_ent.left != '0);
	assign cand_better = !found_q || (rd_ent.prio < best_q.prio) ||
		((rd_ent.prio == best_q.prio) && (rd_ent.arrival < best_q.arrival));

	// load entry and update of the chosen entry
	assign load_ok = (loaded_q < CNT_W'(MAX_TASKS)) && (burst_q != '0);

	assign time_inc = (time_q == TIME_MAX) ? time_q : time_q + 16'd1;
	assign idle_inc = (idle_cnt_q == TIME_MAX) ? idle_cnt_q : idle_cnt_q + 16'd1;
	assign left_dec = best_q.left - 16'd1;
	assign resp_val = best_q.started ? best_q.resp : time_q - best_q.arrival;
	assign done_now = (left_dec == '0);
	assign tat      = time_inc - best_q.arrival;
	assign wt       = (tat >= best_q.burst) ? tat - best_q.burst : '0;
	assign slot_ext = {4'b0000, best_slot_q};

	always_comb begin
		new_ent         = '0;
		new_ent.pid     = pid_q;
		new_ent.arrival = arrival_q;
		new_ent.burst   = burst_q;
		new_ent.prio    = prio_q;
		new_ent.left    = burst_q;

		upd_ent         = best_q;
		upd_ent.left    = left_dec;
		upd_ent.started = 1'b1;
		upd_ent.resp    = resp_val;
	end

	// memory write select
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = loaded_q[SLOT_W-1:0];
		ram_wdata = new_ent;
		if (state_q == ST_LOAD) begin
			ram_we = out_free && load_ok;
		end else if (state_q == ST_COMMIT) begin
			ram_we    = out_free && found_q;
			ram_waddr = best_slot_q;
			ram_wdata = upd_ent;
		end
	end

	assign loaded_nxt    = loaded_q + CNT_W'(1);
	assign completed_nxt = completed_q + CNT_W'(1);

	// control sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			loaded_q     <= '0;
			completed_q  <= '0;
			time_q       <= '0;
			idle_cnt_q   <= '0;
			prev_valid_q <= 1'b0;
			prev_slot_q  <= '1;
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			rsp_valid    <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall && !rsp_set) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						scan_q    <= '0;
						rd_vld_s1 <= 1'b0;
						found_q   <= 1'b0;
						if (opcode == OP_LOAD) begin
							state_q <= ST_LOAD;
						end else if (loaded_q == '0) begin
							state_q <= ST_COMMIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						rsp_valid <= 1'b1;
						if (load_ok) begin
							loaded_q <= loaded_nxt;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (rd_vld_s1 && cand_ready && cand_better) begin
						found_q <= 1'b1;
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						rsp_valid <= 1'b1;
						time_q    <= time_inc;
						if (found_q) begin
							prev_valid_q <= 1'b1;
							prev_slot_q  <= best_slot_q;
							if (done_now) begin
								completed_q <= completed_nxt;
							end
						end else begin
							prev_valid_q <= 1'b0;
							idle_cnt_q   <= idle_inc;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload capture: load fields, scan pipeline and best candidate
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			pid_q     <= pid_in;
			arrival_q <= arrival_in;
			burst_q   <= burst_in;
			prio_q    <= priority_in;
		end
		rd_slot_s1 <= scan_q[SLOT_W-1:0];
		if ((state_q == ST_SCAN) && rd_vld_s1 && cand_ready && cand_better) begin
			best_q      <= rd_ent;
			best_slot_q <= rd_slot_s1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == ST_LOAD) && out_free) begin
			load_error      <= !load_ok;
			idle            <= 1'b0;
			slot            <= '0;
			pid_out         <= '0;
			new_slice       <= 1'b0;
			finished        <= 1'b0;
			finish_time     <= '0;
			turnaround      <= '0;
			waiting         <= '0;
			response        <= '0;
			idle_total      <= idle_cnt_q;
			if (load_ok) begin
				all_done <= (completed_q >= loaded_nxt);
			end else begin
				all_done <= (loaded_q != '0) && (completed_q >= loaded_q);
			end
		end else if ((state_q == ST_COMMIT) && out_free) begin
			load_error      <= 1'b0;
			idle            <= !found_q;
			slot            <= '0;
			pid_out         <= '0;
			new_slice       <= 1'b0;
			finished        <= 1'b0;
			finish_time     <= '0;
			turnaround      <= '0;
			waiting         <= '0;
			response        <= '0;
			idle_total      <= found_q ? idle_cnt_q : idle_inc;
			all_done        <= (loaded_q != '0) && (completed_q >= loaded_q);
			if (found_q) begin
				slot      <= slot_ext[3:0];
				pid_out   <= best_q.pid;
				new_slice <= !prev_valid_q || (prev_slot_q != best_slot_q);
				if (done_now) begin
					finished        <= 1'b1;
					finish_time     <= time_inc;
					turnaround      <= tat;
					waiting         <= wt;
					response        <= resp_val;
					all_done        <= (completed_nxt >= loaded_q);
				end
			end
		end
	end

endmodule

`default_nettype wire
